[sv/sclc_pkg.sv]
// shared types and constants for the stream continuity loss counter
`timescale 1ns / 1ps

package sclc_pkg;

  localparam int ID_W       = 13;
  localparam int CC_W       = 4;
  localparam int TOTAL_W    = 32;
  localparam int IN_TDATA_W = 24;
  localparam int IN_TUSER_W = 1;
  localparam int OUT_TDATA_W = 40;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic            start;
    logic [CC_W-1:0] cc;
    logic [CC_W-1:0] last;
  } gap_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gap_stat_t;

endpackage

[sv/sclc_gap_unit.sv]
// iterative modulo unit: reduces (cc - last - 1) into 0 .. COUNTER_MODULUS-1
`timescale 1ns / 1ps

module sclc_gap_unit
  import sclc_pkg::*;
#(
  parameter int COUNTER_MODULUS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  gap_ctrl_t                          ctrl,
  output gap_stat_t                          stat,
  output logic [$clog2(COUNTER_MODULUS)-1:0] gap
);

  localparam int GAP_W = $clog2(COUNTER_MODULUS);
  localparam int REM_W = ((GAP_W > CC_W + 1) ? GAP_W : CC_W + 1) + 2;
  localparam logic signed [REM_W-1:0] MOD_S = REM_W'(COUNTER_MODULUS);

  logic                    busy;
  logic signed [REM_W-1:0] rem;
  logic                    in_range;

  assign in_range  = (rem >= 0) && (rem < MOD_S);
  assign stat.busy = busy;
  assign stat.done = busy && in_range;
  assign gap       = rem[GAP_W-1:0];

  // one add or subtract of the modulus per cycle until the value lands in range
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
    end else if (busy && in_range) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= $signed(REM_W'(ctrl.cc)) - $signed(REM_W'(ctrl.last)) - REM_W'(1);
    end else if (busy && !in_range) begin
      if (rem < 0) begin
        rem <= rem + MOD_S;
      end else begin
        rem <= rem - MOD_S;
      end
    end
  end

endmodule

[sv/stream_continuity_loss_counter_unit.sv]
// top level: per-stream continuity checker with a table of seen flags, counters and totals
//
//  channel   dir  fields (lowest bit first)
//  s_*       in   tuser: opcode; tdata: stream_id[12:0], cont_count[16:13], zero fill
//  m_*       out  tdata: was_seen[0], gap_added[4:1], missing_total[36:5], zero fill
//
//  a read, a first sighting or an out-of-range id passes through the look and output
//  states before the next accept; a repeat packet also waits in the modulo state for
//  k corrections in the gap unit (at most 1 for modulus 16 or more, at most 8 for modulus 2)
//  after reset all NUM_STREAMS rows of the table are swept and s_tready stays low
//  a result waits in the output register until m_tready; the next item then holds
//  in the output state
`timescale 1ns / 1ps

module stream_continuity_loss_counter_unit
  import sclc_pkg::*;
#(
  parameter int NUM_STREAMS     = 8192,
  parameter int COUNTER_MODULUS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // stream_id, cont_count, zero fill
  input  logic [IN_TUSER_W-1:0]  s_tuser,  // opcode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // was_seen, gap_added, missing_total, zero fill
);

  localparam int ADDR_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int GAP_W  = $clog2(COUNTER_MODULUS);
  localparam int ROW_W  = 1 + TOTAL_W + CC_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // table row: {last counter, total, seen}
  logic [ROW_W-1:0]  mem [NUM_STREAMS];
  logic [ROW_W-1:0]  rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] clr_addr;

  logic              op;
  logic [ID_W-1:0]   stream_id;
  logic [CC_W-1:0]   cont_count;
  logic              id_ok;
  logic              in_acc;

  logic              row_seen;
  logic [TOTAL_W-1:0] row_total;
  logic [CC_W-1:0]   row_last;

  logic              res_seen;
  logic [CC_W-1:0]   res_gap;
  logic [TOTAL_W-1:0] res_total;
  logic              res_load;

  gap_ctrl_t         gctrl;
  gap_stat_t         gstat;
  logic [GAP_W-1:0]  gap;
  logic [GAP_W+CC_W-1:0] gap_x;
  logic [TOTAL_W-1:0] total_sum;

  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;

  assign row_seen  = rd_data[0];
  assign row_total = rd_data[TOTAL_W:1];
  assign row_last  = rd_data[ROW_W-1:TOTAL_W+1];

  assign gap_x     = {{CC_W{1'b0}}, gap};
  assign total_sum = row_total + TOTAL_W'(gap);

  assign gctrl.start = (state == ST_LOOK) && id_ok && (op == OP_PACKET) && row_seen;
  assign gctrl.cc    = cont_count;
  assign gctrl.last  = row_last;

  sclc_gap_unit #(
    .COUNTER_MODULUS(COUNTER_MODULUS)
  ) u_gap (
    .clk (clk),
    .rst (rst),
    .ctrl(gctrl),
    .stat(gstat),
    .gap (gap)
  );

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = stream_id[ADDR_W-1:0];
    mem_wdata  = {cont_count, {TOTAL_W{1'b0}}, 1'b1};
    res_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == ADDR_W'(NUM_STREAMS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (gctrl.start) begin
          state_next = ST_MOD;
        end else begin
          // first sighting starts the entry with a zero total; reads and out-of-range ids write nothing
          mem_we     = id_ok && (op == OP_PACKET);
          res_load   = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_MOD: begin
        if (gstat.done) begin
          mem_we     = 1'b1;
          mem_wdata  = {cont_count, total_sum, 1'b1};
          res_load   = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // table port: one write and one registered read per cycle
  // the read follows the item being accepted so its row is ready in the look state
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[in_acc ? s_tdata[ADDR_W-1:0] : stream_id[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op         <= s_tuser[0];
      stream_id  <= s_tdata[ID_W-1:0];
      cont_count <= s_tdata[ID_W+CC_W-1:ID_W];
      id_ok      <= ({1'b0, s_tdata[ID_W-1:0]} < (ID_W+1)'(NUM_STREAMS));
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      if (state == ST_MOD) begin
        res_seen  <= 1'b1;
        res_gap   <= gap_x[CC_W-1:0];
        res_total <= total_sum;
      end else begin
        res_seen  <= id_ok && row_seen;
        res_gap   <= '0;
        res_total <= (id_ok && row_seen && (op == OP_READ)) ? row_total : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_TDATA_W'({res_total, res_gap, res_seen});
    end
  end

endmodule

[tb/stream_continuity_loss_counter_unit_test.sv]
// testbench for the stream continuity loss counter: packet and read items against a local table
`timescale 1ns / 1ps

module stream_continuity_loss_counter_unit_test;
  import sclc_pkg::*;

  localparam int STREAM_COUNT = 8192;
  localparam int CC_MOD       = 16;

  typedef struct {
    logic              op;
    logic [ID_W-1:0]   sid;
    logic [CC_W-1:0]   cc;
    bit                drain;  // hold this item back until every report is out
  } ts_item_t;

  typedef struct {
    logic               was_seen;
    logic [CC_W-1:0]    gap_added;
    logic [TOTAL_W-1:0] missing_total;
  } loss_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  stream_continuity_loss_counter_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // local copy of the per-stream table
  bit                 seen_tbl [STREAM_COUNT];
  logic [CC_W-1:0]    last_cc_tbl [STREAM_COUNT];
  logic [TOTAL_W-1:0] loss_tbl [STREAM_COUNT];

  ts_item_t     packets_to_send[$];
  loss_report_t loss_reports_due[$];
  ts_item_t     cur_item;
  int           presented_count = 0;
  int           accepted_count = 0;
  int           err_count = 0;
  int           send_gap = 0;
  int           stall_left = 0;

  always #10 clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic loss_report_t track_continuity(ts_item_t it);
    loss_report_t r;
    logic [CC_W-1:0] gap;
    r = '{1'b0, '0, '0};
    if (it.sid < STREAM_COUNT) begin
      r.was_seen = seen_tbl[it.sid];
      if (it.op == OP_PACKET) begin
        if (seen_tbl[it.sid]) begin
          // counter modulus is a power of two, so 4-bit wrap gives the modulo
          gap = it.cc - last_cc_tbl[it.sid] - 1'b1;
          r.gap_added = gap;
          loss_tbl[it.sid] = loss_tbl[it.sid] + TOTAL_W'(gap);
        end else begin
          loss_tbl[it.sid] = '0;
          seen_tbl[it.sid] = 1'b1;
        end
        last_cc_tbl[it.sid] = it.cc;
        r.missing_total = loss_tbl[it.sid];
      end else if (seen_tbl[it.sid]) begin
        r.missing_total = loss_tbl[it.sid];
      end
    end
    return r;
  endfunction

  function automatic ts_item_t mk_item(logic op, int sid, int cc, bit drain = 1'b0);
    ts_item_t it;
    it.op = op;
    it.sid = ID_W'(sid);
    it.cc = CC_W'(cc);
    it.drain = drain;
    return it;
  endfunction

  // idling is off near the end and in every third stretch of 40 items
  function automatic bit idle_allowed();
    return packets_to_send.size() >= 40 && (accepted_count / 40) % 3 != 2;
  endfunction

  // sender side
  always @(negedge clk) begin
    logic nv;
    nv = s_tvalid;
    if (!rst && presented_count == accepted_count) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (packets_to_send.size() != 0 &&
                   !(packets_to_send[0].drain && loss_reports_due.size() != 0)) begin
        cur_item = packets_to_send.pop_front();
        s_tuser <= cur_item.op;
        s_tdata <= {{(IN_TDATA_W - ID_W - CC_W){1'b0}}, cur_item.cc, cur_item.sid};
        nv = 1'b1;
        presented_count++;
        send_gap = (idle_allowed() && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      end
    end
    s_tvalid <= nv;
  end

  // receiver side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // accept, predict and check
  always @(posedge clk) begin
    loss_report_t want;
    loss_report_t got;
    if (!rst && s_tvalid && s_tready) begin
      loss_reports_due.push_back(track_continuity(cur_item));
      accepted_count++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.was_seen = m_tdata[0];
      got.gap_added = m_tdata[4:1];
      got.missing_total = m_tdata[36:5];
      if (loss_reports_due.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: seen %0b gap %0d total %0d",
                   got.was_seen, got.gap_added, got.missing_total);
      end else begin
        want = loss_reports_due.pop_front();
        if (got.was_seen !== want.was_seen || got.gap_added !== want.gap_added ||
            got.missing_total !== want.missing_total) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch: expected seen %0b gap %0d total %0d,",
                      " got seen %0b gap %0d total %0d"},
                     want.was_seen, want.gap_added, want.missing_total,
                     got.was_seen, got.gap_added, got.missing_total);
        end
      end
    end
  end

  initial begin
    int pool_id [16];
    logic [CC_W-1:0] pool_cc [16];
    bit pool_started [16];
    int k;
    int pick;

    // directed: first sighting, in order, duplicate, gaps, wrap, reads
    packets_to_send.push_back(mk_item(OP_READ, 0, 0));
    packets_to_send.push_back(mk_item(OP_READ, 8191, 15));
    packets_to_send.push_back(mk_item(OP_PACKET, 0, 0));
    packets_to_send.push_back(mk_item(OP_PACKET, 0, 1));
    packets_to_send.push_back(mk_item(OP_PACKET, 0, 1));
    packets_to_send.push_back(mk_item(OP_PACKET, 0, 5));
    packets_to_send.push_back(mk_item(OP_PACKET, 0, 4));
    packets_to_send.push_back(mk_item(OP_READ, 0, 15));
    packets_to_send.push_back(mk_item(OP_PACKET, 8191, 15));
    packets_to_send.push_back(mk_item(OP_PACKET, 8191, 0));
    packets_to_send.push_back(mk_item(OP_PACKET, 8191, 15));
    packets_to_send.push_back(mk_item(OP_PACKET, 8191, 15));
    packets_to_send.push_back(mk_item(OP_READ, 8191, 0));
    packets_to_send.push_back(mk_item(OP_PACKET, 'h1555, 10));
    packets_to_send.push_back(mk_item(OP_PACKET, 'h0AAA, 5));
    packets_to_send.push_back(mk_item(OP_READ, 'h1555, 5));
    packets_to_send.push_back(mk_item(OP_READ, 'h0AAA, 10));
    packets_to_send.push_back(mk_item(OP_PACKET, 'h1555, 10));
    packets_to_send.push_back(mk_item(OP_PACKET, 'h0AAA, 4));
    packets_to_send.push_back(mk_item(OP_READ, 'h1555, 0));
    packets_to_send.push_back(mk_item(OP_READ, 'h0AAA, 0));
    packets_to_send.push_back(mk_item(OP_READ, 1, 0, 1'b1));

    // random: mostly in-order streams from a small pool, some loss, reads and noise
    pool_id[0] = 0;
    pool_id[1] = STREAM_COUNT - 1;
    for (k = 2; k < 16; k++) pool_id[k] = $urandom_range(0, STREAM_COUNT - 1);
    for (k = 0; k < 16; k++) begin
      pool_started[k] = 1'b0;
      pool_cc[k] = '0;
    end
    for (k = 0; k < 400; k++) begin
      ts_item_t it;
      int r;
      r = $urandom_range(0, 99);
      pick = $urandom_range(0, 15);
      if (r < 60) begin
        it = mk_item(OP_PACKET, pool_id[pick],
                     pool_started[pick] ? pool_cc[pick] + 1 : $urandom_range(0, CC_MOD - 1));
      end else if (r < 75) begin
        it = mk_item(OP_PACKET, pool_id[pick], $urandom_range(0, CC_MOD - 1));
      end else if (r < 88) begin
        it = mk_item(OP_READ, pool_id[pick], $urandom_range(0, CC_MOD - 1));
      end else begin
        it = mk_item(1'($urandom_range(0, 1)), $urandom_range(0, STREAM_COUNT - 1),
                     $urandom_range(0, CC_MOD - 1));
      end
      if (r < 75) begin
        pool_started[pick] = 1'b1;
        pool_cc[pick] = it.cc;
      end
      it.drain = (k % 100 == 99);
      packets_to_send.push_back(it);
    end

    while (packets_to_send.size() != 0 || presented_count != accepted_count) @(posedge clk);
    while (loss_reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && loss_reports_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // covers the table sweep after reset and every item at its slowest pace many times over
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
sv/sclc_pkg.sv
sv/sclc_gap_unit.sv
sv/stream_continuity_loss_counter_unit.sv
tb/stream_continuity_loss_counter_unit_test.sv
